### sv/krnt_pkg.sv
// ---------------------------------------------------------------------------
// krnt_pkg: shared types and constants of the key range node table
// Holds the entry layout, request and result words, operation codes and the
// sequencer states.
// ---------------------------------------------------------------------------
package krnt_pkg;

  localparam int KEY_W             = 32;
  localparam int NODE_W            = 16;
  localparam int TAG_W             = 32;
  localparam int IDX_W             = 5;
  localparam int TABLE_ENTRIES_DEF = 16;

  typedef enum logic [1:0] {
    ACT_UPSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  start_key;
    logic [KEY_W-1:0]  end_key;
    logic [NODE_W-1:0] node_id;
    logic [TAG_W-1:0]  update_tag;
  } entry_t;

  typedef struct packed {
    action_t           action;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  end_key;
    logic [NODE_W-1:0] node_id;
    logic [TAG_W-1:0]  update_tag;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic              found;
    logic [IDX_W-1:0]  entry_index;
    logic [NODE_W-1:0] match_node;
    logic [NODE_W-1:0] next_node;
  } res_t;

endpackage

### sv/krnt_mem.sv
// ---------------------------------------------------------------------------
// krnt_mem: entry storage
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module krnt_mem #(
  parameter int DEPTH  = krnt_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_W = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  krnt_pkg::entry_t     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output krnt_pkg::entry_t     rd_data
);

  krnt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/krnt_seq.sv
// ---------------------------------------------------------------------------
// krnt_seq: operation sequencer
// Walks the entry memory one entry per cycle, then overwrites, appends,
// shifts entries down or fetches the following node, and forms the result.
// ---------------------------------------------------------------------------
module krnt_seq #(
  parameter int TABLE_ENTRIES = krnt_pkg::TABLE_ENTRIES_DEF,
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  krnt_pkg::req_t    req,
  output logic              idle,
  output logic              res_valid,
  output krnt_pkg::res_t    res,
  input  logic              res_take,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_addr,
  output krnt_pkg::entry_t  mem_wr_data,
  output logic              mem_rd_en,
  output logic [AW-1:0]     mem_rd_addr,
  input  krnt_pkg::entry_t  mem_rd_data
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] ONE  = CW'(1);

  krnt_pkg::state_t state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    rd_ptr, rd_ptr_next;
  logic             chk_vld, chk_vld_next;
  logic [CW-1:0]    chk_idx, chk_idx_next;
  krnt_pkg::req_t   req_r, req_next;
  krnt_pkg::res_t   res_r, res_next;

  logic [CW-1:0] wr_idx;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] nx_idx;
  logic          key_eq;
  logic          in_range;
  logic          hit;

  function automatic logic [krnt_pkg::IDX_W-1:0] to_index(logic [CW-1:0] v);
    logic [CW+krnt_pkg::IDX_W-1:0] w;
    w = {{krnt_pkg::IDX_W{1'b0}}, v};
    return w[krnt_pkg::IDX_W-1:0];
  endfunction

  assign key_eq   = (mem_rd_data.start_key == req_r.key);
  assign in_range = ($signed(mem_rd_data.start_key) <= $signed(req_r.key)) &&
                    ($signed(req_r.key) < $signed(mem_rd_data.end_key));
  assign hit      = chk_vld &&
                    ((req_r.action == krnt_pkg::ACT_LOOKUP) ? in_range : key_eq);
  assign nx_idx   = ((chk_idx + ONE) < count) ? (chk_idx + ONE) : '0;

  assign mem_wr_addr = wr_idx[AW-1:0];
  assign mem_rd_addr = rd_idx[AW-1:0];
  assign res         = res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= krnt_pkg::S_IDLE;
      count   <= '0;
      chk_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      chk_vld <= chk_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr  <= rd_ptr_next;
    chk_idx <= chk_idx_next;
    req_r   <= req_next;
    res_r   <= res_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    rd_ptr_next  = rd_ptr;
    chk_vld_next = chk_vld;
    chk_idx_next = chk_idx;
    req_next     = req_r;
    res_next     = res_r;
    mem_wr_en    = 1'b0;
    wr_idx       = '0;
    mem_wr_data  = '{start_key: req_r.key, end_key: req_r.end_key,
                     node_id: req_r.node_id, update_tag: req_r.update_tag};
    mem_rd_en    = 1'b0;
    rd_idx       = '0;
    idle         = 1'b0;
    res_valid    = 1'b0;

    unique case (state)
      krnt_pkg::S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          req_next     = req;
          rd_ptr_next  = '0;
          chk_vld_next = 1'b0;
          res_next     = '{ok: 1'b0, found: 1'b0, entry_index: to_index(count),
                           match_node: '0, next_node: '0};
          if (req.action == krnt_pkg::ACT_NONE) begin
            state_next = krnt_pkg::S_DONE;
          end else begin
            state_next = krnt_pkg::S_SCAN;
          end
        end
      end

      krnt_pkg::S_SCAN: begin
        if (hit) begin
          chk_vld_next         = 1'b0;
          res_next.ok          = 1'b1;
          res_next.found       = 1'b1;
          res_next.entry_index = to_index(chk_idx);
          unique case (req_r.action)
            krnt_pkg::ACT_UPSERT: begin
              // An equal tag means the stored entry is already current.
              if (mem_rd_data.update_tag != req_r.update_tag) begin
                mem_wr_en = 1'b1;
                wr_idx    = chk_idx;
              end
              state_next = krnt_pkg::S_DONE;
            end
            krnt_pkg::ACT_DELETE: begin
              rd_ptr_next = chk_idx + ONE;
              state_next  = krnt_pkg::S_SHIFT;
            end
            krnt_pkg::ACT_LOOKUP: begin
              res_next.match_node = mem_rd_data.node_id;
              mem_rd_en           = 1'b1;
              rd_idx              = nx_idx;
              state_next          = krnt_pkg::S_NEXT;
            end
            default: begin
              state_next = krnt_pkg::S_DONE;
            end
          endcase
        end else if (rd_ptr < count) begin
          mem_rd_en    = 1'b1;
          rd_idx       = rd_ptr;
          chk_vld_next = 1'b1;
          chk_idx_next = rd_ptr;
          rd_ptr_next  = rd_ptr + ONE;
        end else if (chk_vld) begin
          chk_vld_next = 1'b0;
        end else begin
          // No entry matched: an upsert appends when there is room.
          if (req_r.action == krnt_pkg::ACT_UPSERT && count < FULL) begin
            mem_wr_en   = 1'b1;
            wr_idx      = count;
            count_next  = count + ONE;
            res_next.ok = 1'b1;
          end
          state_next = krnt_pkg::S_DONE;
        end
      end

      krnt_pkg::S_SHIFT: begin
        // Entry j+1 read last cycle is written to position j.
        if (chk_vld) begin
          mem_wr_en   = 1'b1;
          wr_idx      = chk_idx - ONE;
          mem_wr_data = mem_rd_data;
        end
        if (rd_ptr < count) begin
          mem_rd_en    = 1'b1;
          rd_idx       = rd_ptr;
          chk_vld_next = 1'b1;
          chk_idx_next = rd_ptr;
          rd_ptr_next  = rd_ptr + ONE;
        end else if (chk_vld) begin
          chk_vld_next = 1'b0;
        end else begin
          count_next = count - ONE;
          state_next = krnt_pkg::S_DONE;
        end
      end

      krnt_pkg::S_NEXT: begin
        res_next.next_node = mem_rd_data.node_id;
        state_next         = krnt_pkg::S_DONE;
      end

      krnt_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = krnt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = krnt_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("entry count exceeds table size");

  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> (wr_idx <= count) && (wr_idx < FULL))
    else $error("write outside the occupied table");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != krnt_pkg::S_SCAN && state != krnt_pkg::S_SHIFT) |=>
      (count == $past(count)))
    else $error("entry count changed outside an update");

endmodule

### sv/key_range_node_table_core.sv
// ---------------------------------------------------------------------------
// key_range_node_table_core: ordered key range to node lookup table
// Upsert, delete and range lookup over a table of server entries.
// ---------------------------------------------------------------------------
// An operation runs from input word to result word through a walk of the entry
// memory, one entry per cycle on its single read port; a delete adds the shift
// of the later entries, and the spare action code skips the walk.
// Throughput: one operation at a time; a new word is taken once the previous
// result has moved into the output register.
// Reset: synchronous; clears the entry count and the handshakes. The entry
// memory is not cleared, since only entries below the count are ever read.
// ---------------------------------------------------------------------------
module key_range_node_table_core #(
  parameter int TABLE_ENTRIES = krnt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic signed [krnt_pkg::KEY_W-1:0]  key,
  input  logic signed [krnt_pkg::KEY_W-1:0]  end_key,
  input  logic [krnt_pkg::NODE_W-1:0]        node_id,
  input  logic [krnt_pkg::TAG_W-1:0]         update_tag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               ok,
  output logic                               found,
  output logic [krnt_pkg::IDX_W-1:0]         entry_index,
  output logic [krnt_pkg::NODE_W-1:0]        match_node,
  output logic [krnt_pkg::NODE_W-1:0]        next_node
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Request word as it enters the sequencer.
  krnt_pkg::req_t   req;
  logic             start;
  logic             idle;

  // Finished result waiting for the output register.
  logic             res_valid;
  krnt_pkg::res_t   res;
  logic             res_take;

  // Entry memory ports.
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  krnt_pkg::entry_t mem_wr_data;
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  krnt_pkg::entry_t mem_rd_data;

  assign req = '{action: krnt_pkg::action_t'(action), key: key, end_key: end_key,
                 node_id: node_id, update_tag: update_tag};

  // The block takes a word only between operations.
  assign in_stall = !idle;
  assign start    = in_valid && !in_stall;

  // The output register decouples the sequencer from the consumer: a result
  // moves in when the register is empty or is being emptied this cycle.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      ok          <= res.ok;
      found       <= res.found;
      entry_index <= res.entry_index;
      match_node  <= res.match_node;
      next_node   <= res.next_node;
    end
  end

  krnt_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req         (req),
    .idle        (idle),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  krnt_mem #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

### test/tb_key_range_node_table_core.sv
// ---------------------------------------------------------------------------
// tb_key_range_node_table_core: self-checking bench for the key range table
// Drives upsert, delete and range lookup words through the valid/stall input
// channel, predicts every result word from a behavioral copy of the table,
// and checks each result word field by field as it leaves the output channel.
// ---------------------------------------------------------------------------
module tb_key_range_node_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import krnt_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  // The worst operation walks the whole table and shifts it; DRAIN_CYCLES leaves
  // it a comfortable settling time once nothing is pending.
  localparam int DRAIN_CYCLES  = 2 * (TABLE_ENTRIES + 5);
  localparam int DRAIN_LIMIT   = 5000;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [1:0]               action     = '0;
  logic signed [KEY_W-1:0]  key        = '0;
  logic signed [KEY_W-1:0]  end_key    = '0;
  logic [NODE_W-1:0]        node_id    = '0;
  logic [TAG_W-1:0]         update_tag = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b1;
  logic                     ok;
  logic                     found;
  logic [IDX_W-1:0]         entry_index;
  logic [NODE_W-1:0]        match_node;
  logic [NODE_W-1:0]        next_node;

  // Behavioral copy of the table. Only slots below tbl_count are ever read,
  // just as in the block, so the slots need no reset value.
  logic signed [KEY_W-1:0]  tbl_start [TABLE_ENTRIES];
  logic signed [KEY_W-1:0]  tbl_end   [TABLE_ENTRIES];
  logic [NODE_W-1:0]        tbl_node  [TABLE_ENTRIES];
  logic [TAG_W-1:0]         tbl_tag   [TABLE_ENTRIES];
  int                       tbl_count = 0;

  // Result words predicted for accepted input words, oldest first.
  res_t                     expected_results [$];

  // Start keys that the random phases draw from, so that upserts, deletes
  // and lookups keep hitting the same entries.
  logic [KEY_W-1:0]         key_pool [$];

  // Largest idle gap on the input side and largest stall on the output side,
  // in cycles, drawn anew for every word. Zero gives back-to-back traffic.
  int                       max_gap   = 4;
  int                       max_stall = 4;
  int                       errors    = 0;

  always #1 clk = ~clk;

  key_range_node_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .key        (key),
    .end_key    (end_key),
    .node_id    (node_id),
    .update_tag (update_tag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .found      (found),
    .entry_index(entry_index),
    .match_node (match_node),
    .next_node  (next_node)
  );

  // Applies one operation to the table copy and returns the result word the
  // block must produce for it. Misses report the count as the index.
  function automatic res_t table_apply(input logic [1:0] act,
                                       input logic signed [KEY_W-1:0] k,
                                       input logic signed [KEY_W-1:0] ke,
                                       input logic [NODE_W-1:0] nid,
                                       input logic [TAG_W-1:0] tag);
    res_t r;
    int   pos;
    int   nx;
    r = '0;
    r.entry_index = IDX_W'(tbl_count);
    // First slot whose start key equals the key, or the count when none does.
    pos = tbl_count;
    for (int i = tbl_count - 1; i >= 0; i--) begin
      if (tbl_start[i] == k) pos = i;
    end
    case (action_t'(act))
      ACT_UPSERT: begin
        if (pos < tbl_count) begin
          // An equal tag leaves the entry as it is, yet still counts as a hit.
          if (tbl_tag[pos] != tag) begin
            tbl_end[pos]  = ke;
            tbl_node[pos] = nid;
            tbl_tag[pos]  = tag;
          end
          r.ok          = 1'b1;
          r.found       = 1'b1;
          r.entry_index = IDX_W'(pos);
        end else if (tbl_count < TABLE_ENTRIES) begin
          tbl_start[tbl_count] = k;
          tbl_end[tbl_count]   = ke;
          tbl_node[tbl_count]  = nid;
          tbl_tag[tbl_count]   = tag;
          tbl_count++;
          r.ok = 1'b1;
        end
      end
      ACT_DELETE: begin
        if (pos < tbl_count) begin
          for (int j = pos; j + 1 < tbl_count; j++) begin
            tbl_start[j] = tbl_start[j + 1];
            tbl_end[j]   = tbl_end[j + 1];
            tbl_node[j]  = tbl_node[j + 1];
            tbl_tag[j]   = tbl_tag[j + 1];
          end
          tbl_count--;
          r.ok          = 1'b1;
          r.found       = 1'b1;
          r.entry_index = IDX_W'(pos);
        end
      end
      ACT_LOOKUP: begin
        // Signed compare on start <= key < end; an empty range never hits.
        for (int i = 0; i < tbl_count; i++) begin
          if (!r.found && tbl_start[i] <= k && k < tbl_end[i]) begin
            nx            = (i + 1 >= tbl_count) ? 0 : i + 1;
            r.ok          = 1'b1;
            r.found       = 1'b1;
            r.entry_index = IDX_W'(i);
            r.match_node  = tbl_node[i];
            r.next_node   = tbl_node[nx];
          end
        end
      end
      default: begin
        // The spare action code changes nothing and reports a miss.
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Sends one input word. Called at a falling edge; returns at the falling
  // edge after the word was taken, with valid still high so that a following
  // word with no gap can simply replace the payload.
  task automatic send_word(input logic [1:0] act, input logic [KEY_W-1:0] k,
                           input logic [KEY_W-1:0] ke, input logic [NODE_W-1:0] nid,
                           input logic [TAG_W-1:0] tag);
    int gap;
    gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    key        <= k;
    end_key    <= ke;
    node_id    <= nid;
    update_tag <= tag;
    do @(posedge clk); while (!(in_valid && !in_stall));
    // The word is taken at this edge, so the table copy moves on with it.
    expected_results.push_back(table_apply(act, k, ke, nid, tag));
    @(negedge clk);
  endtask

  // Output side: stalls for a random number of cycles before each result
  // word, then takes the next word the block offers and checks it.
  initial begin : result_monitor
    int   hold;
    res_t want;
    forever begin
      @(negedge clk);
      hold = (max_stall > 0) ? $urandom_range(0, max_stall) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_results.size() == 0) begin
        report_mismatch("result word with no input word waiting for it");
      end else begin
        want = expected_results.pop_front();
        compare_field("ok", 32'(ok), 32'(want.ok));
        compare_field("found", 32'(found), 32'(want.found));
        compare_field("entry_index", 32'(entry_index), 32'(want.entry_index));
        compare_field("match_node", 32'(match_node), 32'(want.match_node));
        compare_field("next_node", 32'(next_node), 32'(want.next_node));
      end
    end
  end

  // Refills the key pool: the signed extremes, zero and minus one, and the
  // rest random.
  task automatic build_pool(input int n);
    key_pool.delete();
    key_pool.push_back(32'h8000_0000);
    key_pool.push_back(32'h7FFF_FFFF);
    key_pool.push_back(32'h0000_0000);
    key_pool.push_back(32'hFFFF_FFFF);
    for (int i = 4; i < n; i++) key_pool.push_back($urandom);
  endtask

  // Random traffic. Most words reuse pool keys so that hits, overwrites,
  // shifts and a full table all occur; a share of words carry fully random
  // fields. Range ends usually sit a little above the start, and lookup keys
  // near a pool key, so that lookups fall inside and just outside ranges.
  task automatic run_random(input int n_items, input int upsert_pct,
                            input int delete_pct);
    logic [1:0]       act;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] ke;
    int               sel;
    for (int i = 0; i < n_items; i++) begin
      sel  = $urandom_range(0, 99);
      base = key_pool[$urandom_range(0, key_pool.size() - 1)];
      k    = $urandom;
      ke   = $urandom;
      if (sel < upsert_pct) begin
        act = ACT_UPSERT;
        if ($urandom_range(0, 11) != 0) k = base;
        if ($urandom_range(0, 9) != 0) ke = base + $urandom_range(1, 3000);
      end else if (sel < upsert_pct + delete_pct) begin
        act = ACT_DELETE;
        if ($urandom_range(0, 7) != 0) k = base;
      end else if (sel < 97) begin
        act = ACT_LOOKUP;
        if ($urandom_range(0, 7) != 0) k = base + $urandom_range(0, 3100) - 32'd40;
      end else begin
        act = ACT_NONE;
      end
      // Small tags repeat often, which exercises the equal-tag upsert.
      send_word(act, k, ke, 16'($urandom),
                ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2) : $urandom);
    end
  endtask

  // Operations on an empty table: a lookup miss and the spare action code.
  task automatic test_empty_table();
    send_word(ACT_LOOKUP, 32'h0000_0000, $urandom, 16'($urandom), $urandom);
    send_word(ACT_NONE, $urandom, $urandom, 16'($urandom), $urandom);
  endtask

  // One entry spanning almost the whole signed key space, then tag handling
  // and an entry with an empty range.
  task automatic test_single_entry();
    send_word(ACT_UPSERT, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // Hit with a single entry: the next node is the entry itself.
    send_word(ACT_LOOKUP, 32'h7FFF_FFFE, $urandom, 16'($urandom), $urandom);
    // The end key is exclusive, so the top key misses.
    send_word(ACT_LOOKUP, 32'h7FFF_FFFF, $urandom, 16'($urandom), $urandom);
    // Equal tag: the entry must keep its old range and node.
    send_word(ACT_UPSERT, 32'h8000_0000, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
    // New tag: the entry is overwritten in place.
    send_word(ACT_UPSERT, 32'h8000_0000, 32'h0000_0100, 16'h1234, 32'h0000_0000);
    // End below start: appended, but it can never match a lookup.
    send_word(ACT_UPSERT, 32'h7FFF_FFFF, 32'h8000_0000, 16'hABCD, 32'h0000_0000);
  endtask

  // Fills the table, overflows it, wraps a lookup and deletes from the middle.
  task automatic test_full_table();
    for (int i = 2; i < TABLE_ENTRIES; i++)
      send_word(ACT_UPSERT, 1000 * i, 1000 * i + 1000, 16'(i * 16'h0101), 32'(i));
    // No matching start key and no free slot.
    send_word(ACT_UPSERT, 32'd99, 32'd200, 16'h5555, 32'h0000_0001);
    // The last entry hits, so its next node wraps to entry zero.
    send_word(ACT_LOOKUP, 1000 * (TABLE_ENTRIES - 1) + 5, $urandom, 16'($urandom),
              $urandom);
    send_word(ACT_DELETE, 32'd3000, $urandom, 16'($urandom), $urandom);
    send_word(ACT_DELETE, 32'd42, $urandom, 16'($urandom), $urandom);
  endtask

  // Small key pool, balanced mix: the table churns on the pool keys.
  task automatic test_random_churn();
    build_pool(10);
    max_gap   = 4;
    max_stall = 4;
    run_random(200, 45, 25);
  endtask

  // Large key pool, upsert-heavy: the table fills and upserts start to fail.
  task automatic test_random_fill();
    build_pool(40);
    max_gap   = 2;
    max_stall = 4;
    run_random(180, 70, 8);
  endtask

  // Same pool, delete-heavy: the table drains of its pool-key entries.
  task automatic test_random_drain();
    max_gap   = 4;
    max_stall = 1;
    run_random(150, 15, 60);
  endtask

  // Back-to-back words with the output never stalled.
  task automatic test_back_to_back();
    build_pool(20);
    max_gap   = 0;
    max_stall = 0;
    run_random(100, 40, 25);
  endtask

  // Drops valid, waits for every pending result word and lets the block
  // settle, then flags anything that never arrived.
  task automatic wait_drained();
    int waited;
    waited   = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived",
                                expected_results.size()));
  endtask

  initial begin : test_sequence
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_single_entry();
    test_full_table();
    test_random_churn();
    test_random_fill();
    test_random_drain();
    test_back_to_back();
    wait_drained();
    if (errors == 0) begin
      $display("key_range_node_table_core test passed");
    end else begin
      $display("key_range_node_table_core test failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #1_000_000;
    $display("key_range_node_table_core test failed");
    $finish;
  end

endmodule
